>>> sv/vnf_pkg.sv
// ---------------------------------------------------------------------------
// vnf_pkg
// Shared constants and types of the fractal value noise block.
// ---------------------------------------------------------------------------
package vnf_pkg;

   // default geometry
   localparam int VNF_MAX_OCTAVES = 8;
   localparam int VNF_FRAC_BITS   = 16;

   // payload widths
   localparam int VNF_COORD_W = 32;
   localparam int VNF_NOISE_W = 16;
   localparam int VNF_SEED_W  = 32;
   localparam int VNF_COUNT_W = 4;

   // configuration port
   localparam int VNF_CSR_INDEX_W = 2;
   localparam int VNF_CSR_DATA_W  = 32;

   typedef enum logic [VNF_CSR_INDEX_W-1:0] {
      CSR_NOISE_SEED   = 2'd0,
      CSR_OCTAVE_COUNT = 2'd1
   } csr_index_type;

   // register reset values
   localparam logic [VNF_SEED_W-1:0]  VNF_SEED_RESET  = 32'd0;
   localparam logic [VNF_COUNT_W-1:0] VNF_COUNT_RESET = 4'd4;

   // lattice hash constants
   localparam logic [31:0] VNF_HASH_MUL_X   = 32'd374761393;
   localparam logic [31:0] VNF_HASH_MUL_Z   = 32'd668265263;
   localparam logic [31:0] VNF_HASH_MUL_MIX = 32'd1274126177;
   localparam int          VNF_SEED_STEP    = 131;

endpackage

>>> sv/vnf_if.sv
// ---------------------------------------------------------------------------
// vnf channel interfaces
// Sample request, noise response and register write channels.
// ---------------------------------------------------------------------------
interface vnf_req_if;
   import vnf_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [VNF_COORD_W-1:0] x_coord;
   logic signed [VNF_COORD_W-1:0] z_coord;
   modport source (output valid, output x_coord, output z_coord, input ready);
   modport sink (input valid, input x_coord, input z_coord, output ready);
endinterface

interface vnf_rsp_if;
   import vnf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [VNF_NOISE_W-1:0] noise_value;
   modport source (output valid, output noise_value, input ready);
   modport sink (input valid, input noise_value, output ready);
endinterface

interface vnf_csr_if;
   import vnf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [VNF_CSR_INDEX_W-1:0] index;
   logic [VNF_CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/value_noise_fbm_2d_top.sv
// ---------------------------------------------------------------------------
// value_noise_fbm_2d_top
// Two-dimensional fractal value noise, one sample per cycle unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one sample position (x_coord, z_coord, signed, FRAC_BITS
//   fraction bits); rsp_chan returns one noise_value word per request, in order.
//   csr_chan writes noise_seed (index 0) and octave_count (index 1); it is
//   always ready and should be written only while no sample is in flight.
//   All octave lanes run side by side, so a new word is taken every cycle
//   while the output is not stalled. A word passes eight register stages:
//   input (loaded at the accept edge), hash products, hash mix and
//   smoothstep, row lerp, column lerp, octave sum, reciprocal product,
//   correction.
//   Throughput is one word per cycle while the receiver is ready.
//   When the receiver stalls, each stage holds its word; empty stages still
//   fill, so requests are taken until the whole pipe is full.
//   Reset empties the pipe and restores seed 0 and four octaves.
// ---------------------------------------------------------------------------
module value_noise_fbm_2d_top #(
   parameter int MAX_OCTAVES = vnf_pkg::VNF_MAX_OCTAVES,
   parameter int FRAC_BITS   = vnf_pkg::VNF_FRAC_BITS
) (
   input logic        clock,
   input logic        reset,
   vnf_req_if.sink    req_chan,
   vnf_rsp_if.source  rsp_chan,
   vnf_csr_if.sink    csr_chan
);
   import vnf_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int L      = MAX_OCTAVES;
   localparam int NW     = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W  = VNF_NOISE_W + MAX_OCTAVES;
   localparam int K      = SUM_W;
   localparam int R_W    = K + 1;
   localparam int PROD_W = SUM_W + R_W;
   localparam int QW     = SUM_W + MAX_OCTAVES;
   localparam int STAGES = 8;

   // truncating lerp, result stays between a and b
   function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [F-1:0] u);
      logic [15:0]   diff;
      logic [15+F:0] prod;
      logic [15:0]   step;
      diff = (b >= a) ? (b - a) : (a - b);
      prod = (16 + F)'(diff) * (16 + F)'(u);
      step = prod[15+F:F];
      return (b >= a) ? (a + step) : (a - step);
   endfunction

   // floor-ish reciprocal of 2^n-1 scaled by 2^K, short by at most one
   function automatic logic [R_W-1:0] recip(input int n);
      logic [R_W-1:0] r;
      r = '0;
      for (int k = 1; k <= K; k++) begin
         if (n * k <= K) r = r + (R_W'(1) << (K - n * k));
      end
      return r;
   endfunction

   // configuration registers
   logic [VNF_SEED_W-1:0]  noise_seed_ff;
   logic [VNF_COUNT_W-1:0] octave_count_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_seed_ff   <= VNF_SEED_RESET;
         octave_count_ff <= VNF_COUNT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_NOISE_SEED:   noise_seed_ff <= csr_chan.data[VNF_SEED_W-1:0];
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_chan.data[VNF_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valid bits and per-stage advance
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp_chan.ready;
      for (int s = STAGES - 2; s >= 0; s--) en[s] = !valid_ff[s] || en[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req_chan.valid;
         for (int s = 1; s < STAGES; s++) begin
            if (en[s]) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   assign req_chan.ready = en[0];

   // effective octave count
   logic [NW-1:0] n_in;

   always_comb begin
      if (octave_count_ff == '0) n_in = NW'(1);
      else if (32'(octave_count_ff) > MAX_OCTAVES) n_in = NW'(MAX_OCTAVES);
      else n_in = NW'(octave_count_ff);
   end

   // stage 0: input word
   logic [31:0]           x0_ff, z0_ff, seed0_ff;
   logic [NW-1:0]         n0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x0_ff    <= req_chan.x_coord;
         z0_ff    <= req_chan.z_coord;
         seed0_ff <= noise_seed_ff;
         n0_ff    <= n_in;
      end
   end

   // per-lane stage registers
   logic [31:0]  px0_ff [L], px1_ff [L], pz0_ff [L], pz1_ff [L], seed1_ff [L];
   logic [F-1:0] sqx_ff [L], sqz_ff [L];
   logic [F+1:0] tx_ff [L], tz_ff [L];
   logic [NW-1:0] n1_ff, n2_ff, n3_ff, n4_ff, n5_ff, n6_ff;

   logic [31:0]  hm_ff [L][4];
   logic [F-1:0] ux_ff [L], uz2_ff [L], uz3_ff [L];
   logic [15:0]  r0_ff [L], r1_ff [L];
   logic [15:0]  v_ff [L];

   for (genvar l = 0; l < L; l++) begin : g_lane
      logic [63:0]    xs_in, zs_in;
      logic [31:0]    cx_in, cz_in;
      logic [F-1:0]   fx_in, fz_in;
      logic [2*F-1:0] fxx_in, fzz_in;
      logic [31:0]    h_in [4];
      logic [31:0]    m_in [4];
      logic [2*F+1:0] ux_p_in, uz_p_in;
      logic [15:0]    corner_in [4];

      // stage 1: lattice split, hash products, fraction square
      always_comb begin
         xs_in  = {{32{x0_ff[31]}}, x0_ff} << l;
         zs_in  = {{32{z0_ff[31]}}, z0_ff} << l;
         cx_in  = xs_in[F+31:F];
         cz_in  = zs_in[F+31:F];
         fx_in  = xs_in[F-1:0];
         fz_in  = zs_in[F-1:0];
         fxx_in = (2 * F)'(fx_in) * (2 * F)'(fx_in);
         fzz_in = (2 * F)'(fz_in) * (2 * F)'(fz_in);
      end

      always_ff @(posedge clock) begin
         if (en[1]) begin
            px0_ff[l]   <= cx_in * VNF_HASH_MUL_X;
            px1_ff[l]   <= (cx_in + 32'd1) * VNF_HASH_MUL_X;
            pz0_ff[l]   <= cz_in * VNF_HASH_MUL_Z;
            pz1_ff[l]   <= (cz_in + 32'd1) * VNF_HASH_MUL_Z;
            seed1_ff[l] <= seed0_ff + 32'(VNF_SEED_STEP * l);
            sqx_ff[l]   <= fxx_in[2*F-1:F];
            sqz_ff[l]   <= fzz_in[2*F-1:F];
            tx_ff[l]    <= ((F + 2)'(3) << F) - {1'b0, fx_in, 1'b0};
            tz_ff[l]    <= ((F + 2)'(3) << F) - {1'b0, fz_in, 1'b0};
         end
      end

      // stage 2: hash mix multiply, smoothstep product
      always_comb begin
         h_in[0] = seed1_ff[l] ^ px0_ff[l] ^ pz0_ff[l];
         h_in[1] = seed1_ff[l] ^ px1_ff[l] ^ pz0_ff[l];
         h_in[2] = seed1_ff[l] ^ px0_ff[l] ^ pz1_ff[l];
         h_in[3] = seed1_ff[l] ^ px1_ff[l] ^ pz1_ff[l];
         for (int c = 0; c < 4; c++) m_in[c] = h_in[c] ^ (h_in[c] >> 13);
         ux_p_in = (2 * F + 2)'(sqx_ff[l]) * (2 * F + 2)'(tx_ff[l]);
         uz_p_in = (2 * F + 2)'(sqz_ff[l]) * (2 * F + 2)'(tz_ff[l]);
      end

      always_ff @(posedge clock) begin
         if (en[2]) begin
            for (int c = 0; c < 4; c++) hm_ff[l][c] <= m_in[c] * VNF_HASH_MUL_MIX;
            ux_ff[l]  <= ux_p_in[2*F-1:F];
            uz2_ff[l] <= uz_p_in[2*F-1:F];
         end
      end

      // stage 3: corner values, lerp along x
      always_comb begin
         for (int c = 0; c < 4; c++) begin
            corner_in[c] = hm_ff[l][c][15:0] ^ hm_ff[l][c][31:16];
         end
      end

      always_ff @(posedge clock) begin
         if (en[3]) begin
            r0_ff[l]  <= blend(corner_in[0], corner_in[1], ux_ff[l]);
            r1_ff[l]  <= blend(corner_in[2], corner_in[3], ux_ff[l]);
            uz3_ff[l] <= uz2_ff[l];
         end
      end

      // stage 4: lerp along z
      always_ff @(posedge clock) begin
         if (en[4]) v_ff[l] <= blend(r0_ff[l], r1_ff[l], uz3_ff[l]);
      end
   end

   // octave count travels with the word
   always_ff @(posedge clock) begin
      if (en[1]) n1_ff <= n0_ff;
      if (en[2]) n2_ff <= n1_ff;
      if (en[3]) n3_ff <= n2_ff;
      if (en[4]) n4_ff <= n3_ff;
      if (en[5]) n5_ff <= n4_ff;
      if (en[6]) n6_ff <= n5_ff;
   end

   // stage 5: weighted octave sum
   logic [SUM_W-1:0] sum_in, sum5_ff, sum6_ff;

   always_comb begin
      sum_in = '0;
      for (int l = 0; l < L; l++) begin
         if (l < 32'(n4_ff)) begin
            sum_in = sum_in + (SUM_W'(v_ff[l]) << (32'(n4_ff) - 1 - l));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) sum5_ff <= sum_in;
   end

   // stage 6: reciprocal product
   logic [R_W-1:0]    rcp_in;
   logic [PROD_W-1:0] prod_ff;

   always_comb begin
      rcp_in = '0;
      for (int i = 1; i <= L; i++) begin
         if (32'(n5_ff) == i) rcp_in = recip(i);
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         prod_ff <= PROD_W'(sum5_ff) * PROD_W'(rcp_in);
         sum6_ff <= sum5_ff;
      end
   end

   // stage 7: one-step quotient correction
   logic [SUM_W-1:0] q0_in, q_in;
   logic [QW-1:0]    qd_in, rem_in, div_in;
   logic [VNF_NOISE_W-1:0] noise_ff;

   always_comb begin
      q0_in  = prod_ff[K+SUM_W-1:K];
      qd_in  = (QW'(q0_in) << n6_ff) - QW'(q0_in);
      rem_in = QW'(sum6_ff) - qd_in;
      div_in = (QW'(1) << n6_ff) - QW'(1);
      q_in   = (rem_in >= div_in) ? (q0_in + SUM_W'(1)) : q0_in;
   end

   always_ff @(posedge clock) begin
      if (en[7]) noise_ff <= q_in[VNF_NOISE_W-1:0];
   end

   assign rsp_chan.valid       = valid_ff[STAGES-1];
   assign rsp_chan.noise_value = noise_ff;

endmodule

>>> sv/vnf_checker.sv
// ---------------------------------------------------------------------------
// vnf_checker
// Port-level checks of the fractal value noise block, bound to the top.
// ---------------------------------------------------------------------------
module vnf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] noise_value,
   input logic        csr_ready
);

   // a stalled response word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value))
      else $error("response dropped or changed under stall");

   // reset empties the pipe
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pipe not empty after reset");

   // no response earlier than the pipeline depth after reset
   assert property (@(posedge clock) reset |=> ##6 !rsp_valid)
      else $error("response appeared before pipeline depth");

   // an empty output with a waiting request is always taken
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid |-> req_ready || !$past(req_ready) || $past(reset))
      else $error("request refused with idle output");

   // register writes never stall
   assert property (@(posedge clock) csr_ready)
      else $error("register port stalled");

endmodule

bind value_noise_fbm_2d_top vnf_checker u_vnf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .noise_value (rsp_chan.noise_value),
   .csr_ready   (csr_chan.ready)
);

>>> tb/vnf_checker.sv
// ---------------------------------------------------------------------------
// vnf_tb_checker
// Watches the sample, noise and register channels, computes the expected
// noise word for every accepted sample and compares it with the response.
// ---------------------------------------------------------------------------
module vnf_tb_checker (
   input  logic    clock,
   input  logic    reset,
   vnf_req_if.sink req_mon,
   vnf_rsp_if.sink rsp_mon,
   vnf_csr_if.sink csr_mon,
   output int      fail_count,
   output int      pending_count
);
   import vnf_pkg::*;

   logic [VNF_SEED_W-1:0]  seed_reg;
   logic [VNF_COUNT_W-1:0] octaves_reg;
   logic [VNF_NOISE_W-1:0] noise_queue[$];

   // integer multiply-xorshift lattice hash, low 16 bits kept
   function automatic logic [63:0] corner_hash(logic [31:0] cx, logic [31:0] cz,
                                               logic [31:0] seed);
      logic [31:0] h;
      h = seed;
      h = h ^ (cx * VNF_HASH_MUL_X);
      h = h ^ (cz * VNF_HASH_MUL_Z);
      h = (h ^ (h >> 13)) * VNF_HASH_MUL_MIX;
      return {48'd0, 16'(h ^ (h >> 16))};
   endfunction

   function automatic logic [63:0] smooth_weight(logic [63:0] f);
      logic [63:0] sq;
      logic [63:0] t;
      sq = (f * f) >> VNF_FRAC_BITS;
      t  = (64'd3 << VNF_FRAC_BITS) - 2 * f;
      return (sq * t) >> VNF_FRAC_BITS;
   endfunction

   function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] u);
      if (b >= a) return a + (((b - a) * u) >> VNF_FRAC_BITS);
      return a - (((a - b) * u) >> VNF_FRAC_BITS);
   endfunction

   function automatic logic [VNF_NOISE_W-1:0] fractal_noise(logic [31:0] x, logic [31:0] z);
      logic [63:0] xw, zw, xs, zs, ux, uz, sum, r0, r1, fmask;
      logic [31:0] cx, cz, sd;
      int n;
      n = octaves_reg;
      if (n < 1) n = 1;
      if (n > VNF_MAX_OCTAVES) n = VNF_MAX_OCTAVES;
      xw = {{32{x[31]}}, x};
      zw = {{32{z[31]}}, z};
      fmask = (64'd1 << VNF_FRAC_BITS) - 1;
      sum = 0;
      for (int i = 0; i < n; i++) begin
         sd = seed_reg + 32'(VNF_SEED_STEP * i);
         xs = xw << i;
         zs = zw << i;
         cx = 32'(xs >> VNF_FRAC_BITS);
         cz = 32'(zs >> VNF_FRAC_BITS);
         ux = smooth_weight(xs & fmask);
         uz = smooth_weight(zs & fmask);
         r0 = mix(corner_hash(cx, cz, sd), corner_hash(cx + 1, cz, sd), ux);
         r1 = mix(corner_hash(cx, cz + 1, sd), corner_hash(cx + 1, cz + 1, sd), ux);
         sum += mix(r0, r1, uz) << (n - 1 - i);
      end
      return 16'(sum / ((64'd1 << n) - 1));
   endfunction

   assign pending_count = noise_queue.size();

   // track registers, predict on sample words, compare noise words
   always @(posedge clock) begin
      logic [VNF_NOISE_W-1:0] want;
      if (reset) begin
         seed_reg    <= VNF_SEED_RESET;
         octaves_reg <= VNF_COUNT_RESET;
         noise_queue.delete();
         fail_count  <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            noise_queue.insert(noise_queue.size(),
                               fractal_noise(req_mon.x_coord, req_mon.z_coord));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (noise_queue.size() == 0) begin
               $display("%0t: unexpected noise word %0d", $time, rsp_mon.noise_value);
               fail_count <= fail_count + 1;
            end else begin
               want = noise_queue.pop_front();
               if (want !== rsp_mon.noise_value) begin
                  $display("%0t: noise_value expected %0d actual %0d", $time, want,
                           rsp_mon.noise_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_NOISE_SEED) seed_reg <= csr_mon.data;
            else if (csr_mon.index == CSR_OCTAVE_COUNT) octaves_reg <= csr_mon.data[3:0];
         end
      end
   end
endmodule

>>> tb/value_noise_fbm_2d_top_tb.sv
// ---------------------------------------------------------------------------
// value_noise_fbm_2d_top_tb
// Drives directed and random sample positions through several seed and
// octave settings with random gaps and stalls; the checker judges results.
// ---------------------------------------------------------------------------
module value_noise_fbm_2d_top_tb;
   import vnf_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   bit   steady_phase;
   bit   timed_out;

   vnf_req_if req_chan ();
   vnf_rsp_if rsp_chan ();
   vnf_csr_if csr_chan ();

   value_noise_fbm_2d_top dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   vnf_tb_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink), .csr_mon(csr_chan.sink),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver stalls about a quarter of the time, except in the steady phase
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= steady_phase || ($urandom_range(99) >= 24);
      end
   end

   // watchdog on cycles with no accepted word
   initial begin
      idle_cycles = 0;
      timed_out = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else if (!reset) idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // valid stays high between back-to-back words and drops only in gaps
   task automatic send_sample(logic [31:0] x, logic [31:0] z);
      while (!steady_phase && $urandom_range(99) < 24) begin
         req_chan.valid <= 0;
         @(negedge clock);
      end
      req_chan.valid   <= 1;
      req_chan.x_coord <= x;
      req_chan.z_coord <= z;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] value);
      req_chan.valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_chan.valid <= 1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 0;
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) << 12;
         default: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
      endcase
   endfunction

   initial begin
      logic [31:0] edge_vals[6];
      steady_phase = 0;
      reset = 1;
      req_chan.valid = 0;
      req_chan.x_coord = 0;
      req_chan.z_coord = 0;
      csr_chan.valid = 0;
      csr_chan.index = CSR_NOISE_SEED;
      csr_chan.data = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: coordinate extremes and fraction edges at reset settings
      edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                    32'h0000_ffff, 32'h0001_0000};
      foreach (edge_vals[i]) begin
         send_sample(edge_vals[i], edge_vals[5 - i]);
         send_sample(edge_vals[i], edge_vals[i]);
      end

      // octave count zero, above the maximum, and seed extremes
      write_register(CSR_OCTAVE_COUNT, 0);
      send_sample(32'h7fff_ffff, 32'h8000_0000);
      send_sample(32'h1234_5678, 32'h8765_4321);
      write_register(CSR_OCTAVE_COUNT, 15);
      write_register(CSR_NOISE_SEED, 32'h7fff_ffff);
      send_sample(32'h7fff_ffff, 32'h7fff_ffff);
      send_sample(32'h8000_0000, 32'h0);
      write_register(CSR_OCTAVE_COUNT, 8);
      write_register(CSR_NOISE_SEED, 32'h8000_0000);
      send_sample(32'hffff_ffff, 32'h0000_8000);
      write_register(CSR_NOISE_SEED, 32'hffff_ffff);
      send_sample(32'h0000_8000, 32'hffff_ffff);

      // random phases with random settings; the last phase runs without gaps
      for (int p = 0; p < 9; p++) begin
         write_register(CSR_NOISE_SEED, $urandom);
         write_register(CSR_OCTAVE_COUNT, (p == 0) ? 1 : $urandom_range(15));
         steady_phase = (p == 8);
         repeat (100) send_sample(rand_coord($urandom_range(2)),
                                  rand_coord($urandom_range(2)));
      end

      // drain
      req_chan.valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
